// ===== hdl/cadc_pkg.sv =====
// Shared constants, codes and types of the calibrated ADC percent reporter.
package cadc_pkg;

   localparam int CHANNELS   = 2;
   localparam int ADC_BITS   = 12;
   localparam int CAL_GAP    = 5;
   localparam int FULL_SCALE = 1000;

   localparam int ACT_W      = 3;
   localparam int CH_W       = 2;
   localparam int RAW_W      = 12;
   localparam int TICK_W     = 32;
   localparam int STAT_W     = 2;
   localparam int PCT_W      = 10;
   localparam int MASK_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int CAL_W    = ADC_BITS + 2;
   localparam int DIFF_W   = ADC_BITS + 1;
   localparam int NUM_W    = DIFF_W + PCT_W;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [ACT_W-1:0] ACT_SAMPLE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SET_MIN  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET_MAX  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ECHO_ON  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_ECHO_OFF = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_DISABLED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DELTA    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/cadc_div.sv =====
// Radix-2 restoring divider producing one quotient bit per cycle.
module cadc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cadc_pkg::DIFF_W-1:0]  diff,
   input  logic [cadc_pkg::DIFF_W-1:0]  den,
   output cadc_pkg::div_stat_type       stat,
   output logic [cadc_pkg::PCT_W-1:0]   quot
);

   localparam int CNT_W = $clog2(cadc_pkg::PCT_W + 1);

   logic [cadc_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [cadc_pkg::NUM_W-1:0] dvs_ff, dvs_in;
   logic [cadc_pkg::PCT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       fits;

   assign fits = rem_ff >= dvs_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // scale by full range, align divisor under the top quotient bit
         rem_in  = cadc_pkg::NUM_W'(diff) * cadc_pkg::NUM_W'(cadc_pkg::FULL_SCALE);
         dvs_in  = cadc_pkg::NUM_W'(den) << (cadc_pkg::PCT_W - 1);
         cnt_in  = CNT_W'(cadc_pkg::PCT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         q_in   = {q_ff[cadc_pkg::PCT_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("divider busy and done together");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(1)) |=> done_ff)
      else $error("divider missed its done pulse");

endmodule

// ===== hdl/calibrated_adc_percent_reporter_core.sv =====
// Top level of the calibrated ADC percent reporter: control, channel state, result register.
//
// Each request beat carries an action, a channel, a raw converter reading and a tick count,
// and yields exactly one response beat. A sample is clamped to the channel's calibration
// window and scaled to tenths of a percent (truncated) by a radix-2 divider that retires one
// quotient bit per cycle. A sample runs through S_PREP, S_DIVL, S_DIVW and S_FIN; response
// valid rises as it leaves S_FIN, and the request side is ready again in that same cycle, so
// one sample is done before the next is taken. The ten divider steps run in S_DIVW. A
// sample on a window no wider than the calibration gap skips the divider (S_PREP then S_FIN);
// all other actions and all channel errors go from accept straight to S_FIN. An earlier
// response on rsp_stall holds S_FIN. The response register frees the request side:
// the next request is taken while an earlier response still waits on rsp_stall.
// Configuration writes are always ready and take effect at once; write them only while no
// request is in flight. Unused action codes act as read percent.
module calibrated_adc_percent_reporter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cadc_pkg::ACT_W-1:0]       req_action,
   input  logic [cadc_pkg::CH_W-1:0]        req_channel,
   input  logic [cadc_pkg::RAW_W-1:0]       req_raw,
   input  logic [cadc_pkg::TICK_W-1:0]      req_now_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cadc_pkg::STAT_W-1:0]      rsp_status,
   output logic [cadc_pkg::CH_W-1:0]        rsp_channel_out,
   output logic [cadc_pkg::PCT_W-1:0]       rsp_percent_tenths,
   output logic                             rsp_report,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cadc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cadc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CAL_W  = cadc_pkg::CAL_W;
   localparam int PCT_W  = cadc_pkg::PCT_W;
   localparam int TICK_W = cadc_pkg::TICK_W;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_DIVL = 3'd2;
   localparam logic [2:0] S_DIVW = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   localparam logic [cadc_pkg::RAW_W-1:0] RAW_MASK =
      cadc_pkg::RAW_W'((64'd1 << cadc_pkg::ADC_BITS) - 64'd1);
   localparam logic signed [CAL_W-1:0] GAP_S   = CAL_W'(cadc_pkg::CAL_GAP);
   localparam logic signed [CAL_W:0]   GAP_SPN = (CAL_W + 1)'(cadc_pkg::CAL_GAP);
   localparam logic signed [CAL_W-1:0] HIGH_RST =
      CAL_W'((64'd1 << cadc_pkg::ADC_BITS) - 64'd1);

   // configuration registers
   logic [cadc_pkg::MASK_W-1:0] enable_mask_ff, enable_mask_in;
   logic [PCT_W-1:0]            min_delta_ff, min_delta_in;
   logic [TICK_W-1:0]           min_interval_ff, min_interval_in;

   // per-channel state
   logic signed [CAL_W-1:0] cal_low_ff  [cadc_pkg::CHANNELS];
   logic signed [CAL_W-1:0] cal_low_in  [cadc_pkg::CHANNELS];
   logic signed [CAL_W-1:0] cal_high_ff [cadc_pkg::CHANNELS];
   logic signed [CAL_W-1:0] cal_high_in [cadc_pkg::CHANNELS];
   logic                    echo_on_ff  [cadc_pkg::CHANNELS];
   logic                    echo_on_in  [cadc_pkg::CHANNELS];
   logic                    waiting_ff  [cadc_pkg::CHANNELS];
   logic                    waiting_in  [cadc_pkg::CHANNELS];
   logic [PCT_W-1:0]        last_rep_ff [cadc_pkg::CHANNELS];
   logic [PCT_W-1:0]        last_rep_in [cadc_pkg::CHANNELS];
   logic [TICK_W-1:0]       last_time_ff[cadc_pkg::CHANNELS];
   logic [TICK_W-1:0]       last_time_in[cadc_pkg::CHANNELS];
   logic [PCT_W-1:0]        latest_ff   [cadc_pkg::CHANNELS];
   logic [PCT_W-1:0]        latest_in   [cadc_pkg::CHANNELS];

   // item in flight
   logic [2:0]                        state_ff, state_in;
   logic [cadc_pkg::ACT_W-1:0]        action_ff, action_in;
   logic [cadc_pkg::CH_W-1:0]         ch_ff, ch_in;
   logic [cadc_pkg::RAW_W-1:0]        raw_ff, raw_in;
   logic [TICK_W-1:0]                 now_ff, now_in;
   logic [cadc_pkg::STAT_W-1:0]       status_ff, status_in;
   logic [cadc_pkg::DIFF_W-1:0]       diff_ff, diff_in;
   logic [cadc_pkg::DIFF_W-1:0]       den_ff, den_in;
   logic [PCT_W-1:0]                  pct_ff, pct_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cadc_pkg::STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [cadc_pkg::CH_W-1:0]         rsp_ch_ff, rsp_ch_in;
   logic [PCT_W-1:0]                  rsp_pct_ff, rsp_pct_in;
   logic                              rsp_report_ff, rsp_report_in;

   // datapath terms
   logic [cadc_pkg::CH_IDX_W-1:0]     idx;
   logic signed [CAL_W-1:0]           raw_s, lo_s, hi_s, clamp_s, offs_s;
   logic signed [CAL_W:0]             span_s;
   logic                              narrow;
   logic [PCT_W-1:0]                  last_rep, pct_dist;
   logic [TICK_W-1:0]                 elapsed;
   logic                              changed, waited, report_now;
   logic                              rsp_free, item_ok;
   logic                              range_bad, chan_off;
   logic                              div_start;
   cadc_pkg::div_stat_type            div_stat;
   logic [PCT_W-1:0]                  div_quot;

   assign idx   = ch_ff[cadc_pkg::CH_IDX_W-1:0];
   assign raw_s = $signed(CAL_W'(raw_ff));
   assign lo_s  = cal_low_ff[idx];
   assign hi_s  = cal_high_ff[idx];

   // clamp the reading into the window and measure both spans
   assign clamp_s = (raw_s < lo_s) ? lo_s : ((raw_s > hi_s) ? hi_s : raw_s);
   assign offs_s  = clamp_s - lo_s;
   assign span_s  = (CAL_W + 1)'(hi_s) - (CAL_W + 1)'(lo_s);
   assign narrow  = span_s <= GAP_SPN;

   // echo decision: a waiting report, or enough change after enough ticks
   assign last_rep   = last_rep_ff[idx];
   assign pct_dist   = (pct_ff >= last_rep) ? (pct_ff - last_rep) : (last_rep - pct_ff);
   assign elapsed    = now_ff - last_time_ff[idx];
   assign changed    = pct_dist >= min_delta_ff;
   assign waited     = elapsed >= min_interval_ff;
   assign report_now = echo_on_ff[idx] && (waiting_ff[idx] || (changed && waited));

   assign range_bad = {1'b0, req_channel} >= 3'(cadc_pkg::CHANNELS);
   assign chan_off  = ((enable_mask_ff >> req_channel) & cadc_pkg::MASK_W'(1)) ==
                      cadc_pkg::MASK_W'(0);

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign item_ok   = status_ff == cadc_pkg::ST_OK;
   assign div_start = state_ff == S_DIVL;

   cadc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .diff  (diff_ff),
      .den   (den_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // sequencer and state update
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      ch_in         = ch_ff;
      raw_in        = raw_ff;
      now_in        = now_ff;
      status_in     = status_ff;
      diff_in       = diff_ff;
      den_in        = den_ff;
      pct_in        = pct_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_report_in = rsp_report_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cal_low_in    = cal_low_ff;
      cal_high_in   = cal_high_ff;
      echo_on_in    = echo_on_ff;
      waiting_in    = waiting_ff;
      last_rep_in   = last_rep_ff;
      last_time_in  = last_time_ff;
      latest_in     = latest_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // capture the beat and classify the channel
               action_in = req_action;
               ch_in     = req_channel;
               raw_in    = req_raw & RAW_MASK;
               now_in    = req_now_tick;
               if (range_bad) begin
                  status_in = cadc_pkg::ST_RANGE;
               end else if (chan_off) begin
                  status_in = cadc_pkg::ST_DISABLED;
               end else begin
                  status_in = cadc_pkg::ST_OK;
               end
               if (!range_bad && !chan_off && req_action == cadc_pkg::ACT_SAMPLE) begin
                  state_in = S_PREP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_PREP: begin
            diff_in = offs_s[cadc_pkg::DIFF_W-1:0];
            den_in  = span_s[cadc_pkg::DIFF_W-1:0];
            pct_in  = '0;
            state_in = narrow ? S_FIN : S_DIVL;
         end
         S_DIVL: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_stat.done) begin
               pct_in   = div_quot;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_ch_in     = ch_ff;
               rsp_pct_in    = '0;
               rsp_report_in = 1'b0;
               if (item_ok) begin
                  if (action_ff == cadc_pkg::ACT_SAMPLE) begin
                     rsp_pct_in     = pct_ff;
                     latest_in[idx] = pct_ff;
                     if (report_now) begin
                        rsp_report_in     = 1'b1;
                        waiting_in[idx]   = 1'b0;
                        last_rep_in[idx]  = pct_ff;
                        last_time_in[idx] = now_ff;
                     end
                  end else begin
                     rsp_pct_in = latest_ff[idx];
                     case (action_ff)
                        cadc_pkg::ACT_SET_MIN: begin
                           // push the high end up to keep the gap
                           cal_low_in[idx] = raw_s;
                           if (hi_s <= raw_s + GAP_S) begin
                              cal_high_in[idx] = raw_s + GAP_S;
                           end
                        end
                        cadc_pkg::ACT_SET_MAX: begin
                           // push the low end down to keep the gap
                           cal_high_in[idx] = raw_s;
                           if (raw_s <= lo_s + GAP_S) begin
                              cal_low_in[idx] = raw_s - GAP_S;
                           end
                        end
                        cadc_pkg::ACT_ECHO_ON: begin
                           echo_on_in[idx] = 1'b1;
                           waiting_in[idx] = 1'b1;
                        end
                        cadc_pkg::ACT_ECHO_OFF: begin
                           echo_on_in[idx] = 1'b0;
                           waiting_in[idx] = 1'b0;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      enable_mask_in  = enable_mask_ff;
      min_delta_in    = min_delta_ff;
      min_interval_in = min_interval_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cadc_pkg::REG_ENABLE_MASK:  enable_mask_in  = csr_wdata[cadc_pkg::MASK_W-1:0];
            cadc_pkg::REG_MIN_DELTA:    min_delta_in    = csr_wdata[PCT_W-1:0];
            cadc_pkg::REG_MIN_INTERVAL: min_interval_in = csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      ch_ff         <= ch_in;
      raw_ff        <= raw_in;
      now_ff        <= now_in;
      status_ff     <= status_in;
      diff_ff       <= diff_in;
      den_ff        <= den_in;
      pct_ff        <= pct_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_report_ff <= rsp_report_in;
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         enable_mask_ff  <= cadc_pkg::MASK_W'(3);
         min_delta_ff    <= PCT_W'(10);
         min_interval_ff <= TICK_W'(100);
         for (int c = 0; c < cadc_pkg::CHANNELS; c++) begin
            cal_low_ff[c]   <= '0;
            cal_high_ff[c]  <= HIGH_RST;
            echo_on_ff[c]   <= 1'b0;
            waiting_ff[c]   <= 1'b0;
            last_rep_ff[c]  <= '0;
            last_time_ff[c] <= '0;
            latest_ff[c]    <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         enable_mask_ff  <= enable_mask_in;
         min_delta_ff    <= min_delta_in;
         min_interval_ff <= min_interval_in;
         cal_low_ff      <= cal_low_in;
         cal_high_ff     <= cal_high_in;
         echo_on_ff      <= echo_on_in;
         waiting_ff      <= waiting_in;
         last_rep_ff     <= last_rep_in;
         last_time_ff    <= last_time_in;
         latest_ff       <= latest_in;
      end
   end

   // take a new beat only between items
   assign req_stall          = state_ff != S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_channel_out    = rsp_ch_ff;
   assign rsp_percent_tenths = rsp_pct_ff;
   assign rsp_report         = rsp_report_ff;

   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVW) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on an idle divider");
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (div_quot <= PCT_W'(cadc_pkg::FULL_SCALE)))
      else $error("percent above full scale");
   a_fin_issues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not issued");
   a_window_open: assert property (@(posedge clock) disable iff (reset)
      cal_high_ff[0] > cal_low_ff[0])
      else $error("calibration window collapsed");

endmodule

// ===== dv/calibrated_adc_percent_reporter_checker.sv =====
// Response checker for the calibrated ADC percent reporter: predicts each response and compares.
`timescale 1ns / 100ps

module calibrated_adc_percent_reporter_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [cadc_pkg::ACT_W-1:0]       req_action,
   input  logic [cadc_pkg::CH_W-1:0]        req_channel,
   input  logic [cadc_pkg::RAW_W-1:0]       req_raw,
   input  logic [cadc_pkg::TICK_W-1:0]      req_now_tick,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [cadc_pkg::STAT_W-1:0]      rsp_status,
   input  logic [cadc_pkg::CH_W-1:0]        rsp_channel_out,
   input  logic [cadc_pkg::PCT_W-1:0]       rsp_percent_tenths,
   input  logic                             rsp_report,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [cadc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cadc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               backlog,
   output int                               fault_count
);

   typedef struct packed {
      logic [cadc_pkg::STAT_W-1:0] status;
      logic [cadc_pkg::CH_W-1:0]   channel;
      logic [cadc_pkg::PCT_W-1:0]  percent;
      logic                        report;
   } rsp_beat_type;

   rsp_beat_type due_rsp [$];
   int faults = 0;

   // per-channel copy of the block's state
   logic signed [cadc_pkg::CAL_W-1:0] win_low     [cadc_pkg::CHANNELS];
   logic signed [cadc_pkg::CAL_W-1:0] win_high    [cadc_pkg::CHANNELS];
   logic                              echo_armed  [cadc_pkg::CHANNELS];
   logic                              first_due   [cadc_pkg::CHANNELS];
   logic [cadc_pkg::PCT_W-1:0]        reported_pct[cadc_pkg::CHANNELS];
   logic [cadc_pkg::TICK_W-1:0]       reported_at [cadc_pkg::CHANNELS];
   logic [cadc_pkg::PCT_W-1:0]        held_pct    [cadc_pkg::CHANNELS];

   logic [cadc_pkg::MASK_W-1:0] en_mask;
   logic [cadc_pkg::PCT_W-1:0]  delta_min;
   logic [cadc_pkg::TICK_W-1:0] gap_min;

   assign fault_count = faults;

   task automatic check_field(input string what, input int wanted, input int seen);
      if (wanted != seen) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, wanted, seen);
         faults++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_beat_type                got;
      rsp_beat_type                want;
      int                          ci;
      int                          lo;
      int                          hi;
      int                          pos;
      logic [cadc_pkg::PCT_W-1:0]  pct;
      logic [cadc_pkg::PCT_W-1:0]  drift;
      logic [cadc_pkg::TICK_W-1:0] elapsed;
      logic                        flag;
      if (reset) begin
         for (int c = 0; c < cadc_pkg::CHANNELS; c++) begin
            win_low[c]      = '0;
            win_high[c]     = cadc_pkg::CAL_W'((1 << cadc_pkg::ADC_BITS) - 1);
            echo_armed[c]   = 1'b0;
            first_due[c]    = 1'b0;
            reported_pct[c] = '0;
            reported_at[c]  = '0;
            held_pct[c]     = '0;
         end
         en_mask   = 2'b11;
         delta_min = cadc_pkg::PCT_W'(10);
         gap_min   = cadc_pkg::TICK_W'(100);
         due_rsp.delete();
      end else begin
         // retire the oldest prediction first: it always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_channel_out, rsp_percent_tenths, rsp_report};
            if (due_rsp.size() == 0) begin
               $display({"%0t ns: unexpected response, status %0d channel %0d",
                         " percent %0d report %0d"},
                        $time, got.status, got.channel, got.percent, got.report);
               faults++;
            end else begin
               want = due_rsp.pop_front();
               check_field("status", want.status, got.status);
               check_field("channel_out", want.channel, got.channel);
               check_field("percent_tenths", want.percent, got.percent);
               check_field("report", want.report, got.report);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               cadc_pkg::REG_ENABLE_MASK:  en_mask   = csr_wdata[cadc_pkg::MASK_W-1:0];
               cadc_pkg::REG_MIN_DELTA:    delta_min = csr_wdata[cadc_pkg::PCT_W-1:0];
               cadc_pkg::REG_MIN_INTERVAL: gap_min   = csr_wdata[cadc_pkg::TICK_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            ci           = req_channel;
            pct          = '0;
            flag         = 1'b0;
            want.channel = req_channel;
            if (ci >= cadc_pkg::CHANNELS) begin
               want.status = cadc_pkg::ST_RANGE;
            end else if (!en_mask[ci]) begin
               want.status = cadc_pkg::ST_DISABLED;
            end else begin
               want.status = cadc_pkg::ST_OK;
               lo = win_low[ci];
               hi = win_high[ci];
               case (req_action)
                  cadc_pkg::ACT_SAMPLE: begin
                     // clamp into the window, scale to tenths, truncate
                     pos = req_raw;
                     if (hi > lo + cadc_pkg::CAL_GAP) begin
                        if (pos < lo) pos = lo;
                        if (pos > hi) pos = hi;
                        pct = cadc_pkg::PCT_W'((pos - lo) * cadc_pkg::FULL_SCALE / (hi - lo));
                     end
                     held_pct[ci] = pct;
                     if (echo_armed[ci]) begin
                        drift   = (pct >= reported_pct[ci]) ? pct - reported_pct[ci]
                                                            : reported_pct[ci] - pct;
                        elapsed = req_now_tick - reported_at[ci];
                        if (first_due[ci] || (drift >= delta_min && elapsed >= gap_min)) begin
                           flag             = 1'b1;
                           first_due[ci]    = 1'b0;
                           reported_pct[ci] = pct;
                           reported_at[ci]  = req_now_tick;
                        end
                     end
                  end
                  cadc_pkg::ACT_SET_MIN: begin
                     lo = req_raw;
                     if (hi <= lo + cadc_pkg::CAL_GAP) hi = lo + cadc_pkg::CAL_GAP;
                  end
                  cadc_pkg::ACT_SET_MAX: begin
                     hi = req_raw;
                     if (hi <= lo + cadc_pkg::CAL_GAP) lo = hi - cadc_pkg::CAL_GAP;
                  end
                  cadc_pkg::ACT_ECHO_ON: begin
                     echo_armed[ci] = 1'b1;
                     first_due[ci]  = 1'b1;
                  end
                  cadc_pkg::ACT_ECHO_OFF: begin
                     echo_armed[ci] = 1'b0;
                     first_due[ci]  = 1'b0;
                  end
                  default: ;
               endcase
               win_low[ci]  = cadc_pkg::CAL_W'(lo);
               win_high[ci] = cadc_pkg::CAL_W'(hi);
               if (req_action != cadc_pkg::ACT_SAMPLE) pct = held_pct[ci];
            end
            want.percent = pct;
            want.report  = flag;
            due_rsp.push_back(want);
         end
      end
      backlog <= due_rsp.size();
   end

endmodule

// ===== dv/calibrated_adc_percent_reporter_core_test.sv =====
// Testbench top for the calibrated ADC percent reporter: stimulus, stall pattern and verdict.
`timescale 1ns / 100ps

module calibrated_adc_percent_reporter_core_test;

   // action codes the package leaves unnamed: read percent and the two spare codes
   localparam logic [cadc_pkg::ACT_W-1:0] ACT_READ    = 3'd5;
   localparam logic [cadc_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [cadc_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd7;

   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PASS = 104;
   localparam int IDLE_PERCENT   = 38;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid    = 1'b0;
   logic                            req_stall;
   logic [cadc_pkg::ACT_W-1:0]      req_action   = '0;
   logic [cadc_pkg::CH_W-1:0]       req_channel  = '0;
   logic [cadc_pkg::RAW_W-1:0]      req_raw      = '0;
   logic [cadc_pkg::TICK_W-1:0]     req_now_tick = '0;
   logic                            rsp_valid;
   logic                            rsp_stall    = 1'b0;
   logic [cadc_pkg::STAT_W-1:0]     rsp_status;
   logic [cadc_pkg::CH_W-1:0]       rsp_channel_out;
   logic [cadc_pkg::PCT_W-1:0]      rsp_percent_tenths;
   logic                            rsp_report;
   logic                            csr_valid    = 1'b0;
   logic                            csr_ready;
   logic [cadc_pkg::CSR_IDX_W-1:0]  csr_index    = '0;
   logic [cadc_pkg::CSR_DATA_W-1:0] csr_wdata    = '0;

   int backlog;
   int fault_count;

   // idling on both sides follows this flag; one pass runs with it cleared
   logic idle_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   calibrated_adc_percent_reporter_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_raw            (req_raw),
      .req_now_tick       (req_now_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_channel_out    (rsp_channel_out),
      .rsp_percent_tenths (rsp_percent_tenths),
      .rsp_report         (rsp_report),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   calibrated_adc_percent_reporter_checker audit (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_raw            (req_raw),
      .req_now_tick       (req_now_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_channel_out    (rsp_channel_out),
      .rsp_percent_tenths (rsp_percent_tenths),
      .rsp_report         (rsp_report),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .backlog            (backlog),
      .fault_count        (fault_count)
   );

   // Receiver side: stall at random, independent of rsp_valid, so stalls land on every
   // phase of a response, including the cycle it first shows up.
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Present one request beat and hold it until the block takes it. Valid stays high on
   // return so a back-to-back caller can load the next beat in the same step; any
   // random gap lowers it exactly once per step.
   task automatic put_request(input logic [cadc_pkg::ACT_W-1:0]  act,
                              input logic [cadc_pkg::CH_W-1:0]   ch,
                              input logic [cadc_pkg::RAW_W-1:0]  raw,
                              input logic [cadc_pkg::TICK_W-1:0] tick);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_channel  <= ch;
      req_raw      <= raw;
      req_now_tick <= tick;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every predicted response has been taken, before anything
   // else is written.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write all three registers in index order; only call with the block drained.
   task automatic set_config(input logic [cadc_pkg::MASK_W-1:0] mask,
                             input logic [cadc_pkg::PCT_W-1:0]  delta,
                             input logic [cadc_pkg::TICK_W-1:0] interval);
      logic [cadc_pkg::CSR_DATA_W-1:0] value [3];
      value[cadc_pkg::REG_ENABLE_MASK]  = cadc_pkg::CSR_DATA_W'(mask);
      value[cadc_pkg::REG_MIN_DELTA]    = cadc_pkg::CSR_DATA_W'(delta);
      value[cadc_pkg::REG_MIN_INTERVAL] = cadc_pkg::CSR_DATA_W'(interval);
      for (int r = cadc_pkg::REG_ENABLE_MASK; r <= cadc_pkg::REG_MIN_INTERVAL; r++) begin
         csr_valid <= 1'b1;
         csr_index <= cadc_pkg::CSR_IDX_W'(r);
         csr_wdata <= value[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                          pass_items;
      int                          roll;
      logic [cadc_pkg::ACT_W-1:0]  act;
      logic [cadc_pkg::CH_W-1:0]   ch;
      logic [cadc_pkg::RAW_W-1:0]  raw;
      logic [cadc_pkg::TICK_W-1:0] tick_now;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset configuration: full-scale ends, read and spare codes,
      // out-of-range channels.
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'h000, 32'h0000_0000);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'hFFF, 32'hFFFF_FFFF);
      put_request(ACT_READ, 2'd1, 12'hAAA, 32'h5555_5555);
      put_request(ACT_SPARE_A, 2'd0, 12'h555, 32'hAAAA_AAAA);
      put_request(ACT_SPARE_B, 2'd1, 12'h000, 32'h0000_0001);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd2, 12'h064, 32'h0000_0002);
      put_request(cadc_pkg::ACT_ECHO_ON, 2'd3, 12'h000, 32'h0000_0003);

      // Calibration pushes: min at the top pushes max past full scale, max at zero
      // drags min negative, leaving a window no wider than the gap.
      put_request(cadc_pkg::ACT_SET_MIN, 2'd0, 12'hFFF, 32'd3);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'hFFF, 32'd4);
      put_request(cadc_pkg::ACT_SET_MAX, 2'd0, 12'h000, 32'd5);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'h000, 32'd6);
      put_request(cadc_pkg::ACT_SET_MIN, 2'd0, 12'h000, 32'd7);
      put_request(cadc_pkg::ACT_SET_MAX, 2'd0, 12'd3000, 32'd8);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd1500, 32'd9);

      // Echo: first sample after enable, a small change, a change too soon, a change
      // after the interval, then elapsed time across the tick wrap both ways.
      put_request(cadc_pkg::ACT_ECHO_ON, 2'd0, 12'h000, 32'd10);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd1500, 32'd20);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd1520, 32'd60);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd2000, 32'd110);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd2000, 32'd130);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd0, 32'hFFFF_FFF0);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd3000, 32'h0000_0010);
      put_request(cadc_pkg::ACT_ECHO_OFF, 2'd0, 12'h000, 32'h0000_0011);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd3000, 32'h0000_1000);

      // Channel 1 window squeezed against both ends of the converter range.
      put_request(cadc_pkg::ACT_SET_MAX, 2'd1, 12'd10, 32'd12);
      put_request(cadc_pkg::ACT_SET_MIN, 2'd1, 12'd4090, 32'd13);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd1, 12'hFFF, 32'd14);

      // Disabled channels: nothing may change on them.
      drain_responses();
      set_config(2'b01, 10'd10, 32'd100);
      put_request(cadc_pkg::ACT_SET_MIN, 2'd1, 12'd0, 32'd15);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd1, 12'd100, 32'd16);
      drain_responses();
      set_config(2'b00, 10'd0, 32'd0);
      put_request(cadc_pkg::ACT_SAMPLE, 2'd0, 12'd100, 32'd17);

      // Random passes, one register setting each; every pass starts from a drained
      // block, so the sender pauses for the full backlog at each boundary.
      tick_now = $urandom();
      for (int p = 0; p < PHASES; p++) begin
         drain_responses();
         case (p)
            0:       set_config(2'b11, 10'd10, 32'd100);
            1:       set_config(2'b11, 10'd0, 32'd0);
            2:       set_config(2'b10, 10'd1000, 32'hFFFF_FFFF);
            3:       set_config(2'b01, cadc_pkg::PCT_W'($urandom_range(50, 1)),
                                $urandom_range(500));
            default: set_config(2'b11, cadc_pkg::PCT_W'($urandom_range(1000)),
                                $urandom_range(300));
         endcase
         idle_on    = (p != 1);
         pass_items = 0;
         while (pass_items < ITEMS_PER_PASS) begin
            roll = $urandom_range(99);
            if ($urandom_range(9) == 0)
               ch = cadc_pkg::CH_W'($urandom_range(3, cadc_pkg::CHANNELS));
            else
               ch = cadc_pkg::CH_W'($urandom_range(cadc_pkg::CHANNELS - 1));
            if (roll < 55)      act = cadc_pkg::ACT_SAMPLE;
            else if (roll < 63) act = cadc_pkg::ACT_SET_MIN;
            else if (roll < 71) act = cadc_pkg::ACT_SET_MAX;
            else if (roll < 79) act = cadc_pkg::ACT_ECHO_ON;
            else if (roll < 85) act = cadc_pkg::ACT_ECHO_OFF;
            else                act = cadc_pkg::ACT_W'($urandom_range(ACT_SPARE_B, ACT_READ));
            case ($urandom_range(9))
               0:       raw = '0;
               1:       raw = '1;
               2:       raw = cadc_pkg::RAW_W'($urandom_range(40));
               default: raw = cadc_pkg::RAW_W'($urandom());
            endcase
            // keep most windows wide so samples land inside them
            if (act == cadc_pkg::ACT_SET_MIN && $urandom_range(4) != 0)
               raw = cadc_pkg::RAW_W'($urandom_range(1500));
            if (act == cadc_pkg::ACT_SET_MAX && $urandom_range(4) != 0)
               raw = cadc_pkg::RAW_W'($urandom_range(4095, 2500));
            // ticks mostly advance slowly; now and then jump anywhere, wrap included
            if ($urandom_range(19) == 0)
               tick_now = $urandom();
            else
               tick_now += $urandom_range(150);
            put_request(act, ch, raw, tick_now);
            pass_items++;
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cadc_pkg.sv
hdl/cadc_div.sv
hdl/calibrated_adc_percent_reporter_core.sv
dv/calibrated_adc_percent_reporter_checker.sv
dv/calibrated_adc_percent_reporter_core_test.sv
